/* rtl/core/rcu_pkg.sv */
// Shared constants for the ring complement edge unranking block.
// No dependencies; imported by the core and its checker.
package rcu_pkg;

    localparam int NODE_BITS = 32;
    localparam int NB        = NODE_BITS;
    localparam int IDX_W     = 63;
    localparam int OUT_W     = 32;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam int TW = 2 * NB;
    localparam int DW = 2 * NB;
    localparam int XW = 2 * NB + 3;
    localparam int PW = 2 * NB + 2;
    localparam int CW = ((IDX_W > 2 * NB) ? IDX_W : 2 * NB) + 1;
    localparam int SN = NB + 1;

    localparam logic [0:0] REG_NODE_COUNT     = 1'b0;
    localparam logic [0:0] REG_LATTICE_DEGREE = 1'b1;

endpackage

/* rtl/core/ring_complement_edge_unrank.sv */
// Ring complement edge unranking: pipelined divider and integer square root.
// Depends on rcu_pkg. Items pass through registers a, b, c, the d chain and f
// to output g; one item is accepted per cycle while the pipeline advances.
// The whole pipeline advances whenever the output register is empty or taken.
// Reset clears the valid bits and sets node_count to 8 and lattice_degree to 2.
module ring_complement_edge_unrank (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [rcu_pkg::ADDR_W-1:0]   paddr,
    input  logic [rcu_pkg::DATA_W-1:0]   pwdata,
    output logic [rcu_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         pair_valid,
    output logic                         pair_ready,
    input  logic [rcu_pkg::IDX_W-1:0]    pair_index,
    output logic                         node_valid,
    input  logic                         node_ready,
    output logic [rcu_pkg::OUT_W-1:0]    node_u,
    output logic [rcu_pkg::OUT_W-1:0]    node_v,
    output logic                         index_bad
);
    import rcu_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [NB-1:0]    n;
        logic [NB-1:0]    half;
        logic [NB-1:0]    m;
        logic             badcfg;
    } sa_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [NB-1:0]    half;
        logic [NB-1:0]    m;
        logic [2*NB-1:0]  nm;
        logic [2*NB-1:0]  rect;
        logic [2*NB-1:0]  trim;
        logic             badcfg;
    } sb_t;

    typedef struct packed {
        logic [DW-1:0] drem;
        logic [NB-1:0] q;
        logic [XW-1:0] srem;
        logic [NB:0]   sq;
        logic [NB-1:0] half;
        logic [NB-1:0] m;
        logic [TW-1:0] tp;
        logic          bad;
        logic          in_rect;
    } sd_t;

    typedef struct packed {
        logic [PW-1:0] prod;
        logic [NB-1:0] r;
        logic [NB-1:0] q;
        logic [NB-1:0] crect;
        logic [NB-1:0] half;
        logic [NB-1:0] m;
        logic [TW-1:0] tp;
        logic          bad;
        logic          in_rect;
    } sf_t;

    typedef struct packed {
        logic [NB-1:0] u;
        logic [NB-1:0] v;
        logic          bad;
    } sg_t;

    logic [NB-1:0] n_reg;
    logic [NB-1:0] k_reg;

    sa_t a_reg, a_next;
    sb_t b_reg, b_next;
    sd_t c_reg, c_next;
    sd_t d_reg  [0:SN-1];
    sd_t d_next [0:SN-1];
    sd_t d_src  [0:SN-1];
    sf_t f_reg, f_next;
    sg_t g_reg, g_next;

    logic          va_reg, vb_reg, vc_reg, vf_reg, vg_reg;
    logic [SN-1:0] vd_reg;
    logic          en;

    logic [CW-1:0] idx_x;
    logic [TW-1:0] tp_w;
    logic [NB:0]   r_w;
    logic [NB-1:0] r_n;
    logic [TW-1:0] c_tri;
    logic [NB-1:0] u_sel;
    logic [NB-1:0] c_sel;

    assign pready     = 1'b1;
    assign en         = !vg_reg || node_ready;
    assign pair_ready = en;
    assign node_valid = vg_reg;
    assign node_u     = OUT_W'(g_reg.u);
    assign node_v     = OUT_W'(g_reg.v);
    assign index_bad  = g_reg.bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg <= NB'(8);
            k_reg <= NB'(2);
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[2])
                REG_NODE_COUNT:     n_reg <= pwdata[NB-1:0];
                REG_LATTICE_DEGREE: k_reg <= pwdata[NB-1:0];
                default:            n_reg <= n_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_NODE_COUNT:     prdata = DATA_W'(n_reg);
            REG_LATTICE_DEGREE: prdata = DATA_W'(k_reg);
            default:            prdata = '0;
        endcase
    end

    always_comb
    begin
        a_next.idx    = pair_index;
        a_next.n      = n_reg;
        a_next.half   = k_reg >> 1;
        a_next.m      = n_reg - k_reg - NB'(1);
        a_next.badcfg = k_reg[0]
                      || ({2'b00, n_reg} < ({2'b00, k_reg} + (NB+2)'(3)));
    end

    always_comb
    begin
        b_next.idx    = a_reg.idx;
        b_next.half   = a_reg.half;
        b_next.m      = a_reg.m;
        b_next.badcfg = a_reg.badcfg;
        b_next.nm     = (2*NB)'(a_reg.n) * (2*NB)'(a_reg.m);
        b_next.rect   = (2*NB)'(a_reg.half + NB'(1)) * (2*NB)'(a_reg.m);
        b_next.trim   = ((2*NB)'(a_reg.m - NB'(1)) * (2*NB)'(a_reg.m)) >> 1;
    end

    always_comb
    begin
        idx_x          = CW'(b_reg.idx);
        tp_w           = TW'(b_reg.trim) - TW'(1) - TW'(b_reg.idx) + TW'(b_reg.rect);
        c_next.drem    = DW'(b_reg.idx);
        c_next.q       = '0;
        c_next.srem    = {tp_w, 3'b001};
        c_next.sq      = '0;
        c_next.half    = b_reg.half;
        c_next.m       = b_reg.m;
        c_next.tp      = tp_w;
        c_next.bad     = b_reg.badcfg || (idx_x >= CW'(b_reg.nm >> 1));
        c_next.in_rect = idx_x < CW'(b_reg.rect);
    end

    always_comb
    begin
        sd_t           nxt;
        logic [DW-1:0] dtrial;
        logic [XW-1:0] strial;
        d_src[0] = c_reg;
        for (int s = 1; s < SN; s++)
        begin
            d_src[s] = d_reg[s-1];
        end
        for (int s = 0; s < SN; s++)
        begin
            nxt    = d_src[s];
            dtrial = '0;
            if (s < NB)
            begin
                dtrial = DW'(d_src[s].m) << (NB - 1 - s);
                if (d_src[s].drem >= dtrial)
                begin
                    nxt.drem          = d_src[s].drem - dtrial;
                    nxt.q[NB - 1 - s] = 1'b1;
                end
            end
            strial = (XW'(d_src[s].sq) << (NB - s + 1)) | (XW'(1) << (2 * (NB - s)));
            if (d_src[s].srem >= strial)
            begin
                nxt.srem       = d_src[s].srem - strial;
                nxt.sq[NB - s] = 1'b1;
            end
            d_next[s] = nxt;
        end
    end

    always_comb
    begin
        r_w            = (d_reg[SN-1].sq - (NB+1)'(1)) >> 1;
        r_n            = r_w[NB-1:0];
        f_next.prod    = PW'({1'b0, r_n} + (NB+1)'(1)) * PW'({1'b0, r_n} + (NB+1)'(2));
        f_next.r       = r_n;
        f_next.q       = d_reg[SN-1].q;
        f_next.crect   = d_reg[SN-1].drem[NB-1:0];
        f_next.half    = d_reg[SN-1].half;
        f_next.m       = d_reg[SN-1].m;
        f_next.tp      = d_reg[SN-1].tp;
        f_next.bad     = d_reg[SN-1].bad;
        f_next.in_rect = d_reg[SN-1].in_rect;
    end

    always_comb
    begin
        c_tri = TW'(f_reg.prod >> 1) - TW'(1) - f_reg.tp;
        if (f_reg.in_rect)
        begin
            u_sel = f_reg.q;
            c_sel = f_reg.crect;
        end
        else
        begin
            u_sel = f_reg.half + f_reg.m - NB'(1) - f_reg.r;
            c_sel = c_tri[NB-1:0];
        end
        g_next.bad = f_reg.bad;
        if (f_reg.bad)
        begin
            g_next.u = '0;
            g_next.v = '0;
        end
        else
        begin
            g_next.u = u_sel;
            g_next.v = f_reg.half + NB'(1) + u_sel + c_sel;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= '0;
            vf_reg <= 1'b0;
            vg_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= pair_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= {vd_reg[SN-2:0], vc_reg};
            vf_reg <= vd_reg[SN-1];
            vg_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_next;
            b_reg <= b_next;
            c_reg <= c_next;
            for (int s = 0; s < SN; s++)
            begin
                d_reg[s] <= d_next[s];
            end
            f_reg <= f_next;
            g_reg <= g_next;
        end
    end

endmodule

/* rtl/core/rcu_checker.sv */
// Port-level checker for ring_complement_edge_unrank, attached by bind.
// Depends on rcu_pkg for the output width.
module rcu_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      pair_valid,
    input logic                      pair_ready,
    input logic                      node_valid,
    input logic                      node_ready,
    input logic [rcu_pkg::OUT_W-1:0] node_u,
    input logic [rcu_pkg::OUT_W-1:0] node_v,
    input logic                      index_bad
);
    import rcu_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        node_valid && !node_ready |=> node_valid && $stable(node_u)
            && $stable(node_v) && $stable(index_bad))
        else $error("Result item changed while stalled.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        node_ready |-> pair_ready)
        else $error("Input stalled while output is being taken.");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        node_valid && index_bad |-> node_u == '0 && node_v == '0)
        else $error("Flagged item carries nonzero nodes.");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        node_valid && !index_bad |-> node_v > node_u)
        else $error("Decoded edge is not ordered.");

endmodule

bind ring_complement_edge_unrank rcu_checker u_rcu_checker (.*);

/* test/edge_unrank_checker.sv */
// Checker for the ring complement edge unranking block: predicts each decoded edge
// from the index and the current node count and degree, and compares the results.
// Depends on rcu_pkg; the testbench top supplies the register values it writes.
`timescale 1ns / 100ps

module edge_unrank_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [31:0]                  nodes_cfg,
    input  logic [31:0]                  degree_cfg,
    input  logic                         pair_valid,
    input  logic                         pair_ready,
    input  logic [rcu_pkg::IDX_W-1:0]    pair_index,
    input  logic                         node_valid,
    input  logic                         node_ready,
    input  logic [rcu_pkg::OUT_W-1:0]    node_u,
    input  logic [rcu_pkg::OUT_W-1:0]    node_v,
    input  logic                         index_bad,
    output int                           error_count,
    output int                           pending_edges,
    output int                           edges_seen,
    output int                           bad_seen
);
    import rcu_pkg::*;

    typedef struct packed {
        logic [31:0] u;
        logic [31:0] v;
        logic        bad;
    } edge_t;

    edge_t expected_edges[$];

    function automatic logic [63:0] triangle(input logic [63:0] r);
        return (r * (r + 64'd1)) >> 1;
    endfunction

    function automatic edge_t decode_pair(input logic [62:0] idx_in,
                                          input logic [31:0] n_in,
                                          input logic [31:0] k_in);
        logic [63:0] idx, n, k, half, m, total, rect, u, c, t, tp, lo, hi, mid;
        edge_t e;
        idx = {1'b0, idx_in};
        n = {32'd0, n_in};
        k = {32'd0, k_in};
        e = '{u: 32'd0, v: 32'd0, bad: 1'b1};
        if (k[0] || n < k + 64'd3)
            return e;
        half = k >> 1;
        m = n - k - 64'd1;
        total = (n * m) >> 1;
        if (idx >= total)
            return e;
        rect = (half + 64'd1) * m;
        if (idx < rect) begin
            u = idx / m;
            c = idx % m;
        end else begin
            t = idx - rect;
            tp = triangle(m - 64'd1) - 64'd1 - t;
            lo = 0;
            hi = m - 64'd2;
            while (lo < hi) begin
                mid = lo + (hi - lo + 64'd1) / 64'd2;
                if (triangle(mid) <= tp)
                    lo = mid;
                else
                    hi = mid - 64'd1;
            end
            u = half + 64'd1 + (m - 64'd2 - lo);
            c = triangle(lo + 64'd1) - 64'd1 - tp;
        end
        e.u = u[31:0];
        e.v = 32'(half + 64'd1 + u + c);
        e.bad = 1'b0;
        return e;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        edge_t want;
        if (!rst_n)
        begin
            error_count <= 0;
            edges_seen <= 0;
            bad_seen <= 0;
            expected_edges.delete();
        end
        else
        begin
            if (pair_valid && pair_ready)
                expected_edges.push_back(decode_pair(pair_index, nodes_cfg, degree_cfg));
            if (node_valid && node_ready)
            begin
                edges_seen <= edges_seen + 1;
                if (index_bad)
                    bad_seen <= bad_seen + 1;
                if (expected_edges.size() == 0)
                begin
                    if (error_count < 10)
                        $display("Unexpected edge u=%0d v=%0d bad=%0b",
                                 node_u, node_v, index_bad);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = expected_edges.pop_front();
                    if (want.u !== node_u || want.v !== node_v || want.bad !== index_bad)
                    begin
                        if (error_count < 10)
                            $display("Edge mismatch: expected u=%0d v=%0d bad=%0b, got u=%0d v=%0d bad=%0b",
                                     want.u, want.v, want.bad, node_u, node_v, index_bad);
                        error_count <= error_count + 1;
                    end
                end
            end
        end
    end

    assign pending_edges = expected_edges.size();

endmodule

/* test/testbench.sv */
// Testbench top for ring_complement_edge_unrank: writes node count and degree
// over APB, streams directed and random pair indices, and gives the verdict.
// Depends on rcu_pkg, the block, and edge_unrank_checker.
`timescale 1ns / 100ps

module testbench;
    import rcu_pkg::*;

    localparam int LATENCY = NODE_BITS + 6;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;
    logic pair_valid;
    logic pair_ready;
    logic [IDX_W-1:0] pair_index;
    logic node_valid;
    logic node_ready;
    logic [OUT_W-1:0] node_u;
    logic [OUT_W-1:0] node_v;
    logic index_bad;
    logic [31:0] nodes_cfg;
    logic [31:0] degree_cfg;
    logic hold_receiver;
    int error_count;
    int pending_edges;
    int edges_seen;
    int bad_seen;
    int sent_count;

    ring_complement_edge_unrank dut (.*);

    edge_unrank_checker checker_inst (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("*** FAILED ***");
        $finish;
    end

    task automatic write_register(input logic [0:0] reg_id, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(reg_id) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        if (reg_id == REG_NODE_COUNT)
            nodes_cfg <= value;
        else
            degree_cfg <= value;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] n, input logic [31:0] k);
        pair_valid <= 1'b0;
        @(posedge clk);
        while (pending_edges != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        write_register(REG_NODE_COUNT, n);
        write_register(REG_LATTICE_DEGREE, k);
    endtask

    task automatic send_pair(input logic [62:0] idx);
        int gap;
        gap = $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_valid <= 1'b1;
        pair_index <= idx;
        @(posedge clk);
        while (!pair_ready)
            @(posedge clk);
        sent_count++;
    endtask

    function automatic logic [62:0] total_pairs(input logic [31:0] n, input logic [31:0] k);
        logic [63:0] nn, m;
        nn = {32'd0, n};
        m = nn - {32'd0, k} - 64'd1;
        return 63'((nn * m) >> 1);
    endfunction

    function automatic logic [62:0] random_index(input logic [62:0] total);
        logic [62:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return r;
            1: return total + 63'($urandom_range(0, 3));
            2: return total - 63'd1 - 63'($urandom_range(0, 3));
            default: return (total == 0) ? r : r % total;
        endcase
    endfunction

    task automatic random_phase(input logic [31:0] n, input logic [31:0] k, input int count);
        logic [62:0] total;
        total = total_pairs(n, k);
        configure(n, k);
        for (int i = 0; i < count; i++)
            send_pair(random_index(total));
    endtask

    initial
    begin
        int wait_n;
        node_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            wait_n = $urandom_range(0, 3);
            if (wait_n != 0 || hold_receiver)
            begin
                node_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
                while (hold_receiver)
                    @(posedge clk);
            end
            node_ready <= 1'b1;
            @(posedge clk);
            while (!node_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        hold_receiver = 1'b0;
        wait (sent_count >= 120);
        @(posedge clk);
        hold_receiver <= 1'b1;
        repeat (150) @(posedge clk);
        hold_receiver <= 1'b0;
    end

    initial
    begin
        logic [62:0] total;
        int wait_cycles;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pair_valid = 1'b0;
        pair_index = '0;
        nodes_cfg = 32'd8;
        degree_cfg = 32'd2;
        sent_count = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        total = total_pairs(32'd8, 32'd2);
        send_pair(63'd0);
        send_pair(63'd14);
        send_pair(63'd15);
        send_pair(total - 63'd1);
        send_pair(total);
        send_pair({63{1'b1}});
        configure(32'd3, 32'd0);
        send_pair(63'd0);
        send_pair(63'd1);
        send_pair(63'd2);
        configure(32'd9, 32'd3);
        send_pair(63'd0);
        configure(32'd4, 32'd2);
        send_pair(63'd0);
        configure(32'hFFFF_FFFF, 32'hFFFF_FFFC);
        send_pair(63'd0);
        send_pair(63'd1);
        send_pair(63'd2);
        configure(32'hFFFF_FFFF, 32'd0);
        total = total_pairs(32'hFFFF_FFFF, 32'd0);
        send_pair(63'd0);
        send_pair(total - 63'd1);
        send_pair(total);
        send_pair(63'h2AAA_AAAA_AAAA_AAAA);
        send_pair(63'h5555_5555_5555_5555);

        random_phase(32'd12, 32'd4, 80);
        random_phase(32'd40, 32'd10, 60);
        random_phase(32'd7, 32'd1, 20);
        random_phase(32'hFFFF_FFFF, 32'd2, 60);
        random_phase(32'hFFFF_FFFE, 32'hFFFF_FF00, 40);
        random_phase($urandom, 32'($urandom_range(0, 1000)) << 1, 60);
        random_phase(32'd1000, 32'd500, 40);
        random_phase(32'd3, 32'd0, 20);
        pair_valid <= 1'b0;

        wait_cycles = 0;
        while (pending_edges != 0 && wait_cycles < 10000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 4) @(posedge clk);
        $display("Sent %0d pair indices over fourteen register settings,", sent_count);
        $display("with one long receiver stall; %0d edges checked, %0d flagged bad.",
                 edges_seen, bad_seen);
        if (error_count == 0 && pending_edges == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
